[hw/rtl/tart_pkg.sv]
// Shared constants and types for the tensor axis reversal transpose block.
package tart_pkg;

    localparam int MAX_EXTENT_DEF   = 8;
    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int ELEM_WIDTH_DEF   = 32;

    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_FOUR  = 3'd3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_STORED   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RETURNED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

    // Setup steps derive the strides and element count after reset or a config write.
    typedef enum logic [1:0] {
        ST_SETUP_C,
        ST_SETUP_D,
        ST_SETUP_T,
        ST_RUN
    } t_state;

endpackage

[hw/rtl/tart_if.sv]
// Handshake channel interfaces: request, response and configuration write.
interface tart_req_if import tart_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [DATA_W-1:0] elem_in;

    modport source (output valid, output req_type, output elem_in, input ready);
    modport sink   (input valid, input req_type, input elem_in, output ready);
endinterface

interface tart_rsp_if import tart_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] elem_out;
    logic                     last_out;

    modport source (output valid, output status, output elem_out, output last_out,
                    input ready);
    modport sink   (input valid, input status, input elem_out, input last_out,
                    output ready);
endinterface

interface tart_cfg_if import tart_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/tensor_axis_reversal_transpose.sv]
// Top level of the four-axis tensor reversal (4-D transpose) block.
//
// Usage: a request channel carries load items (req_type 0, element in elem_in)
// and read items (req_type 1). Loads fill the tensor in row-major order until
// extent_one*extent_two*extent_three*extent_four elements are held; reads then
// walk the tensor with all axes reversed, flagging the final element with
// last_out, after which the block is back in the load phase. Items in the
// wrong phase get status "rejected". Every request transfer yields exactly one
// response transfer.
// Throughput: one item per cycle while the receiver keeps up; each item makes at
// most one access to the element RAM. A request passes through the read stage
// (RAM read) and then the output register, which drives response valid.
// Reset, and every config write to a defined register, restart the load phase
// and run setup steps C, D and T to derive strides (one registered multiply each);
// request ready is low during those steps. Stored elements survive both.
// When the receiver stalls, one item sits in the read stage and one in the
// output register; request ready drops once both are occupied.
module tensor_axis_reversal_transpose import tart_pkg::*; #(
    parameter int MAX_EXTENT   = MAX_EXTENT_DEF,
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int ELEM_WIDTH   = ELEM_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tart_req_if.sink    i_req,
    tart_rsp_if.source  o_rsp,
    tart_cfg_if.sink    i_cfg
);

    localparam int EW     = $clog2(MAX_EXTENT + 1);
    localparam int IW     = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;
    localparam int PROD_W = $clog2(MAX_EXTENT ** 4 + 1);
    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int LW     = $clog2(MAX_ELEMENTS + 1);

    // Raw extent registers
    logic [CFG_DATA_W-1:0] r_ext [4];

    t_state r_state, n_state;

    // Derived geometry
    logic [PROD_W-1:0] r_s_c, r_s_d;
    logic [LW-1:0]     r_total;

    // Load side
    logic [LW-1:0] r_load_count;
    logic          r_full;

    // Read walk: counters a (outermost) .. d (innermost) and running bases
    logic [IW-1:0]     r_a, r_b, r_c, r_d;
    logic [PROD_W-1:0] r_base_a, r_base_b, r_base_c, r_addr;

    // Read stage and output register
    logic                r_s1_valid, r_s1_inrange, r_s1_last;
    logic [STATUS_W-1:0] r_s1_status;
    logic                r_out_valid, r_out_last;
    logic [STATUS_W-1:0] r_out_status;
    logic [DATA_W-1:0]   r_out_elem;

    logic [EW-1:0] w_e [4];
    logic          w_cfg_hit, w_s1_adv, w_accept, w_run;
    logic          w_do_load, w_do_read;
    logic          w_step_c, w_step_d, w_step_t;
    logic [PROD_W-1:0] w_prod_t;

    // Effective extents: zero acts as one, above the maximum clamps.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_ext[i] == '0) begin
                w_e[i] = EW'(1);
            end else if (32'(r_ext[i]) > 32'(MAX_EXTENT)) begin
                w_e[i] = EW'(MAX_EXTENT);
            end else begin
                w_e[i] = EW'(r_ext[i]);
            end
        end
    end

    assign w_cfg_hit = i_cfg.valid && (i_cfg.index == CFG_EXTENT_ONE ||
                       i_cfg.index == CFG_EXTENT_TWO || i_cfg.index == CFG_EXTENT_THREE ||
                       i_cfg.index == CFG_EXTENT_FOUR);
    assign i_cfg.ready = 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SETUP_C: n_state = ST_SETUP_D;
            ST_SETUP_D: n_state = ST_SETUP_T;
            ST_SETUP_T: n_state = ST_RUN;
            ST_RUN:     n_state = ST_RUN;
            default:    n_state = ST_SETUP_C;
        endcase
        if (w_cfg_hit) begin
            n_state = ST_SETUP_C;
        end
    end

    // State outputs
    always_comb begin
        w_step_c = 1'b0;
        w_step_d = 1'b0;
        w_step_t = 1'b0;
        w_run    = 1'b0;
        unique case (r_state)
            ST_SETUP_C: w_step_c = 1'b1;
            ST_SETUP_D: w_step_d = 1'b1;
            ST_SETUP_T: w_step_t = 1'b1;
            ST_RUN:     w_run    = 1'b1;
            default:    w_run    = 1'b0;
        endcase
    end

    assign w_s1_adv    = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = w_run && (!r_s1_valid || w_s1_adv);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_do_load   = w_accept && (i_req.req_type == REQ_LOAD) && !r_full;
    assign w_do_read   = w_accept && (i_req.req_type == REQ_READ) && r_full;

    assign w_prod_t = PROD_W'(w_e[0]) * r_s_d;

    // Geometry: one multiply per setup step
    always_ff @(posedge i_clk) begin
        if (w_step_c) begin
            r_s_c <= PROD_W'(w_e[2]) * PROD_W'(w_e[3]);
        end
        if (w_step_d) begin
            r_s_d <= PROD_W'(w_e[1]) * r_s_c;
        end
        if (w_step_t) begin
            r_total <= (32'(w_prod_t) > 32'(MAX_ELEMENTS)) ? LW'(MAX_ELEMENTS)
                                                             : LW'(w_prod_t);
        end
    end

    // Element RAM
    logic [ELEM_WIDTH+DATA_W-1:0] w_wwide, w_rwide;
    logic [PROD_W+ADDR_W-1:0]     w_raddr_wide;
    logic [ELEM_WIDTH-1:0]        w_rdata;
    logic                         w_inrange;

    assign w_wwide      = {ELEM_WIDTH'(0), i_req.elem_in};
    assign w_raddr_wide = {ADDR_W'(0), r_addr};
    assign w_inrange    = 32'(r_addr) < 32'(MAX_ELEMENTS);
    assign w_rwide      = {DATA_W'(0), w_rdata};

    tart_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_do_load),
        .i_waddr (r_load_count[ADDR_W-1:0]),
        .i_wdata (w_wwide[ELEM_WIDTH-1:0]),
        .i_re    (w_do_read && w_inrange),
        .i_raddr (w_raddr_wide[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Walk control: which counter is at its end
    logic w_d_end, w_c_end, w_b_end, w_a_end, w_wrap;
    assign w_d_end = EW'(r_d) == w_e[0] - EW'(1);
    assign w_c_end = EW'(r_c) == w_e[1] - EW'(1);
    assign w_b_end = EW'(r_b) == w_e[2] - EW'(1);
    assign w_a_end = EW'(r_a) == w_e[3] - EW'(1);
    assign w_wrap  = w_d_end && w_c_end && w_b_end && w_a_end;

    logic [LW:0] w_load_next;
    assign w_load_next = (LW + 1)'(r_load_count) + (LW + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SETUP_C;
            for (int i = 0; i < 4; i++) begin
                r_ext[i] <= CFG_DATA_W'(1);
            end
            r_load_count <= '0;
            r_full       <= 1'b0;
            r_a          <= '0;
            r_b          <= '0;
            r_c          <= '0;
            r_d          <= '0;
            r_base_a     <= '0;
            r_base_b     <= '0;
            r_base_c     <= '0;
            r_addr       <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_hit) begin
                r_ext[i_cfg.index[1:0]] <= i_cfg.data;
                r_load_count <= '0;
                r_full       <= 1'b0;
                r_a          <= '0;
                r_b          <= '0;
                r_c          <= '0;
                r_d          <= '0;
                r_base_a     <= '0;
                r_base_b     <= '0;
                r_base_c     <= '0;
                r_addr       <= '0;
            end else if (w_do_load) begin
                r_load_count <= w_load_next[LW-1:0];
                if (w_load_next >= (LW + 1)'(r_total)) begin
                    r_full <= 1'b1;
                end
            end else if (w_do_read) begin
                // Innermost axis steps by the largest stride; on a carry the
                // next outer base moves and the inner bases restart from it.
                if (!w_d_end) begin
                    r_d    <= r_d + IW'(1);
                    r_addr <= r_addr + r_s_d;
                end else if (!w_c_end) begin
                    r_d      <= '0;
                    r_c      <= r_c + IW'(1);
                    r_base_c <= r_base_c + r_s_c;
                    r_addr   <= r_base_c + r_s_c;
                end else if (!w_b_end) begin
                    r_d      <= '0;
                    r_c      <= '0;
                    r_b      <= r_b + IW'(1);
                    r_base_b <= r_base_b + PROD_W'(w_e[3]);
                    r_base_c <= r_base_b + PROD_W'(w_e[3]);
                    r_addr   <= r_base_b + PROD_W'(w_e[3]);
                end else if (!w_a_end) begin
                    r_d      <= '0;
                    r_c      <= '0;
                    r_b      <= '0;
                    r_a      <= r_a + IW'(1);
                    r_base_a <= r_base_a + PROD_W'(1);
                    r_base_b <= r_base_a + PROD_W'(1);
                    r_base_c <= r_base_a + PROD_W'(1);
                    r_addr   <= r_base_a + PROD_W'(1);
                end else begin
                    // Whole tensor returned: back to loading.
                    r_load_count <= '0;
                    r_full       <= 1'b0;
                    r_a          <= '0;
                    r_b          <= '0;
                    r_c          <= '0;
                    r_d          <= '0;
                    r_base_a     <= '0;
                    r_base_b     <= '0;
                    r_base_c     <= '0;
                    r_addr       <= '0;
                end
            end

            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Read-stage and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_inrange <= w_do_read && w_inrange;
            r_s1_last    <= w_do_read && w_wrap;
            if (w_do_load) begin
                r_s1_status <= STATUS_STORED;
            end else if (w_do_read) begin
                r_s1_status <= STATUS_RETURNED;
            end else begin
                r_s1_status <= STATUS_REJECTED;
            end
        end
        if (w_s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_last   <= r_s1_last;
            r_out_elem   <= r_s1_inrange ? w_rwide[DATA_W-1:0] : '0;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.elem_out = signed'(r_out_elem);
    assign o_rsp.last_out = r_out_last;

endmodule

[hw/rtl/tart_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tart_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
